>>> rtl/ymcrc_pkg.sv
// Shared types, protocol codes and the CRC-16 byte update for the YMODEM-CRC receiver.
// No dependencies; imported by ymcrc_core and ymodem_crc_packet_receiver.
package ymcrc_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int SMALL_PAYLOAD = 128;
    localparam int LARGE_PAYLOAD = 1024;
    localparam int SMALL_SHIFT   = $clog2(SMALL_PAYLOAD);
    localparam int LARGE_SHIFT   = $clog2(LARGE_PAYLOAD);
    localparam int POS_W         = 11;
    localparam int LEN_W         = 11;
    localparam int MAX_RES       = 3;
    localparam int RES_CNT_W     = 2;
    localparam int RES_IDX_W     = 2;
    localparam int TDATA_W       = 80;

    // frame openers
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;

    // response bytes
    localparam logic [31:0] R_ACK  = 32'h0000_0006;
    localparam logic [31:0] R_NAK  = 32'h0000_0015;
    localparam logic [31:0] R_POLL = 32'h0000_0043;

    localparam logic [31:0] END_MARK = 32'h1122_AABB;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // result kinds
    localparam logic [2:0] KIND_STAGE  = 3'd0;
    localparam logic [2:0] KIND_SEND   = 3'd1;
    localparam logic [2:0] KIND_ERASE  = 3'd2;
    localparam logic [2:0] KIND_COMMIT = 3'd3;
    localparam logic [2:0] KIND_MARKER = 3'd4;
    localparam logic [2:0] KIND_RESET  = 3'd5;

    // session modes
    localparam logic [1:0] MODE_WAIT = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // packet types
    localparam logic [1:0] PT_NONE = 2'd0;
    localparam logic [1:0] PT_SOH  = 2'd1;
    localparam logic [1:0] PT_STX  = 2'd2;

    // configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    typedef struct packed {
        logic [2:0]       kind;
        logic [31:0]      address;
        logic [31:0]      value;
        logic [LEN_W-1:0] length;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]  count;
        t_result [MAX_RES-1:0] slot;
    } t_res_set;

    function automatic t_result mk_result(input logic [2:0] kind, input logic [31:0] addr,
                                          input logic [31:0] value,
                                          input logic [LEN_W-1:0] len);
        t_result r;
        r.kind    = kind;
        r.address = addr;
        r.value   = value;
        r.length  = len;
        return r;
    endfunction

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> rtl/ymcrc_core.sv
// Protocol state of the YMODEM-CRC receiver: frame parsing, CRC, block checks and
// the set of results one byte causes. Depends on ymcrc_pkg.
module ymcrc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    input  logic [31:0]         i_base,
    input  logic [31:0]         i_size,
    output ymcrc_pkg::t_res_set o_res
);
    import ymcrc_pkg::*;

    logic [1:0]             r_mode,  n_mode;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [POS_W-1:0]       r_pos,   n_pos;
    logic [1:0]             r_ptype, n_ptype;
    logic [7:0]             r_blk,   n_blk;
    logic [7:0]             r_comp,  n_comp;
    logic [15:0]            r_crc,   n_crc;
    logic [7:0]             r_rcv_hi, n_rcv_hi;
    logic                   r_open,  n_open;

    logic [POS_W-1:0] pay_end;
    logic [LEN_W-1:0] psize;
    logic [31:0]      commit_addr;
    logic             comp_ok;
    logic             zero_blk;
    logic             crc_ok;
    t_res_set         res;

    always_comb begin
        pay_end  = (r_ptype == PT_SOH) ? POS_W'(SMALL_PAYLOAD + 3) : POS_W'(LARGE_PAYLOAD + 3);
        psize    = (r_ptype == PT_SOH) ? LEN_W'(SMALL_PAYLOAD) : LEN_W'(LARGE_PAYLOAD);
        // commit index is the count before the increment
        commit_addr = i_base + ((r_ptype == PT_SOH) ? (32'(r_count) << SMALL_SHIFT)
                                                    : (32'(r_count) << LARGE_SHIFT));
        comp_ok  = (r_comp == ~r_blk);
        zero_blk = (r_blk == 8'd0) && comp_ok;
        crc_ok   = (r_crc == {r_rcv_hi, i_byte});
    end

    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        n_pos    = r_pos;
        n_ptype  = r_ptype;
        n_blk    = r_blk;
        n_comp   = r_comp;
        n_crc    = r_crc;
        n_rcv_hi = r_rcv_hi;
        n_open   = r_open;
        res      = '0;

        if (i_start) begin
            n_open  = 1'b0;
            n_pos   = '0;
            n_ptype = PT_NONE;
            case (i_byte)
                B_SOH, B_STX: begin
                    n_open   = 1'b1;
                    n_ptype  = (i_byte == B_SOH) ? PT_SOH : PT_STX;
                    n_pos    = POS_W'(1);
                    n_blk    = '0;
                    n_comp   = '0;
                    n_crc    = '0;
                    n_rcv_hi = '0;
                end
                B_EOT: begin
                    if (r_mode == MODE_RECV) begin
                        n_mode      = MODE_END;
                        res.slot[0] = mk_result(KIND_SEND, '0, R_NAK, '0);
                        res.count   = RES_CNT_W'(1);
                    end else if (r_mode == MODE_END) begin
                        res.slot[0] = mk_result(KIND_SEND, '0, R_ACK, '0);
                        res.slot[1] = mk_result(KIND_SEND, '0, R_POLL, '0);
                        res.count   = RES_CNT_W'(2);
                    end
                end
                default: ;
            endcase
        end else if (r_open) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos == POS_W'(1)) begin
                n_blk = i_byte;
            end else if (r_pos == POS_W'(2)) begin
                n_comp = i_byte;
            end else if (r_pos < pay_end) begin
                n_crc       = crc16_byte(r_crc, i_byte);
                res.slot[0] = mk_result(KIND_STAGE, 32'(r_pos - POS_W'(3)), 32'(i_byte), '0);
                res.count   = RES_CNT_W'(1);
            end else if (r_pos == pay_end) begin
                n_rcv_hi = i_byte;
            end else begin
                // final CRC byte: close the frame and judge it
                n_open = 1'b0;
                if (!crc_ok) begin
                    res.slot[0] = mk_result(KIND_SEND, '0, R_NAK, '0);
                    res.count   = RES_CNT_W'(1);
                end else if (r_ptype == PT_SOH && r_mode == MODE_WAIT && zero_blk) begin
                    n_mode      = MODE_RECV;
                    n_count     = '0;
                    res.slot[0] = mk_result(KIND_ERASE, i_base, '0, '0);
                    res.slot[1] = mk_result(KIND_SEND, '0, R_ACK, '0);
                    res.count   = RES_CNT_W'(2);
                end else if (r_ptype == PT_SOH && r_mode == MODE_END && zero_blk) begin
                    n_mode      = MODE_WAIT;
                    res.slot[0] = mk_result(KIND_SEND, '0, R_ACK, '0);
                    res.slot[1] = mk_result(KIND_MARKER, i_base + i_size - 32'd4,
                                            END_MARK, '0);
                    res.slot[2] = mk_result(KIND_RESET, '0, '0, '0);
                    res.count   = RES_CNT_W'(3);
                end else if ((r_ptype != PT_SOH || r_mode == MODE_RECV) && comp_ok) begin
                    if (r_blk == r_count[7:0]) begin
                        // duplicate of the last accepted block
                        res.slot[0] = mk_result(KIND_SEND, '0, R_ACK, '0);
                        res.count   = RES_CNT_W'(1);
                    end else begin
                        n_count     = r_count + COUNT_WIDTH'(1);
                        res.slot[0] = mk_result(KIND_COMMIT, commit_addr, '0, psize);
                        res.slot[1] = mk_result(KIND_SEND, '0, R_ACK, '0);
                        res.count   = RES_CNT_W'(2);
                    end
                end else begin
                    res.slot[0] = mk_result(KIND_SEND, '0, R_NAK, '0);
                    res.count   = RES_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_WAIT;
            r_count  <= '0;
            r_pos    <= '0;
            r_ptype  <= PT_NONE;
            r_blk    <= '0;
            r_comp   <= '0;
            r_crc    <= '0;
            r_rcv_hi <= '0;
            r_open   <= 1'b0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_ptype  <= n_ptype;
            r_blk    <= n_blk;
            r_comp   <= n_comp;
            r_crc    <= n_crc;
            r_rcv_hi <= n_rcv_hi;
            r_open   <= n_open;
        end
    end

    assign o_res = res;

endmodule

>>> rtl/ymodem_crc_packet_receiver.sv
// YMODEM-CRC download receiver. Takes one serial byte per transfer on the slave
// stream (frame_start in tuser marks the opening byte of a frame) and emits
// stage, send, erase, commit, marker and reset results on the master stream.
// A byte is judged in the cycle it is accepted and its results (up to three)
// are held in a small output buffer; the next byte is taken in the same cycle
// the last of them is transferred, so payload bytes stream at one per cycle
// while m_axis_tready stays high. The CRC-16 byte update and the position
// counter advance in the cycle a byte is accepted. update_base
// (index 0) and update_size (index 1) are written on the cfg channel, which is
// always ready. Depends on ymcrc_pkg and ymcrc_core.
module ymodem_crc_packet_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    // input byte stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tuser,   // [0] frame_start
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ymcrc_pkg::TDATA_W-1:0]  m_axis_tdata,   // [31:0] address, [63:32] value,
                                                           // [74:64] length, [79:75] zero
    output logic [2:0]                     m_axis_tuser,   // [2:0] kind
    output logic                           m_axis_tlast    // last
);
    import ymcrc_pkg::*;

    logic [31:0]          r_base;
    logic [31:0]          r_size;
    t_result              r_slot [MAX_RES];
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_IDX_W-1:0] r_idx;

    t_res_set res;
    t_result  cur;
    logic     in_xfer;
    logic     out_xfer;
    logic     at_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE: r_base <= i_cfg_data;
                CFG_SIZE: r_size <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign at_last       = (RES_CNT_W'(r_idx) == r_cnt - RES_CNT_W'(1));
    assign m_axis_tvalid = (r_cnt != '0);
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    // take a new byte once the buffer is empty or its final result leaves now
    assign s_axis_tready = (r_cnt == '0) || (out_xfer && at_last);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    ymcrc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_base  (r_base),
        .i_size  (r_size),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (in_xfer) begin
            r_cnt <= res.count;
            r_idx <= '0;
        end else if (out_xfer) begin
            if (at_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_slot[k] <= res.slot[k];
            end
        end
    end

    always_comb begin
        case (r_idx)
            RES_IDX_W'(1): cur = r_slot[1];
            RES_IDX_W'(2): cur = r_slot[2];
            default:       cur = r_slot[0];
        endcase
    end

    assign m_axis_tdata = {(TDATA_W - 75)'(0), cur.length, cur.value, cur.address};
    assign m_axis_tuser = cur.kind;
    assign m_axis_tlast = at_last;

endmodule
